FILE: rtl/sha256_compression_macros.svh
// Assertion macros for the SHA-256 compression block checker.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef SHA256_COMPRESSION_MACROS_SVH
`define SHA256_COMPRESSION_MACROS_SVH

// Check on every edge outside reset.
`define SHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sha256_pkg.sv
// Types, constants and round functions for the SHA-256 compression block.
// Depends on nothing; used by the round unit, the schedule and the top level.
package sha256_pkg;

	localparam int ROUNDS = 64;
	localparam int WINDOW = 16;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] vars_t;
	typedef logic [WINDOW-1:0][31:0] window_t;

	typedef enum logic [1:0] {
		MODE_IV    = 2'd0,
		MODE_CHAIN = 2'd1,
		MODE_MSG   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} sched_ctrl_t;

	localparam vars_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: rtl/sha256_round.sv
// Shared SHA-256 round unit: one round on the eight working variables.
// Depends on sha256_pkg.
module sha256_round (
	input  sha256_pkg::vars_t v_in,
	input  sha256_pkg::word_t k,
	input  sha256_pkg::word_t w,
	output sha256_pkg::vars_t v_out
);

	sha256_pkg::word_t t1;
	sha256_pkg::word_t t2;
	sha256_pkg::word_t ch;
	sha256_pkg::word_t maj;

	assign ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
	assign maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
	assign t1  = v_in[7] + sha256_pkg::big_s1(v_in[4]) + ch + k + w;
	assign t2  = sha256_pkg::big_s0(v_in[0]) + maj;

	always_comb begin
		v_out[7] = v_in[6];
		v_out[6] = v_in[5];
		v_out[5] = v_in[4];
		v_out[4] = v_in[3] + t1;
		v_out[3] = v_in[2];
		v_out[2] = v_in[1];
		v_out[1] = v_in[0];
		v_out[0] = t1 + t2;
	end

endmodule

FILE: rtl/sha256_sched.sv
// Message schedule: sixteen-word shift line that expands one word per round.
// Depends on sha256_pkg.
module sha256_sched (
	input  logic                    clk,
	input  sha256_pkg::sched_ctrl_t ctrl,
	input  sha256_pkg::window_t     load_words,
	output sha256_pkg::word_t       wt
);

	sha256_pkg::window_t w_q;
	sha256_pkg::word_t   w_new;

	assign wt    = w_q[0];
	assign w_new = sha256_pkg::small_s1(w_q[14]) + w_q[9]
		+ sha256_pkg::small_s0(w_q[1]) + w_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			w_q <= load_words;
		end else if (ctrl.shift) begin
			for (int i = 0; i < sha256_pkg::WINDOW - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha256_pkg::WINDOW-1] <= w_new;
		end
	end

endmodule

FILE: rtl/sha256_compression.sv
// SHA-256 compression block top level: sequencer, chaining value, window.
// Depends on sha256_pkg, sha256_round and sha256_sched.
//
//  channel | handshake            | fields
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | mode, word_index, data_word
//  out     | out_valid / out_stall| digest_word, digest_index, digest_last
//
// A reset, chaining or message item other than word 15 is taken whenever the block is idle.
// Message word 15 starts 64 rounds at one per cycle in the shared round unit,
// then the chaining add in ST_ADD, then eight digest items in ST_EMIT.
// in_stall is high from word 15 until the last digest item is taken;
// out_stall holds the current digest item.
// arst_n loads the standard initial hash into the chaining value.
module sha256_compression (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  word_index,
	input  logic [31:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	sha256_pkg::state_t      state_q;
	sha256_pkg::state_t      state_nx;
	sha256_pkg::vars_t       chain_q;
	sha256_pkg::vars_t       v_q;
	sha256_pkg::vars_t       v_round;
	sha256_pkg::window_t     window_q;
	sha256_pkg::window_t     load_words;
	sha256_pkg::sched_ctrl_t sched_ctrl;
	sha256_pkg::word_t       wt;
	logic [5:0]              rnd_q;
	logic [2:0]              idx_q;
	logic                    in_acc;
	logic                    start;

	assign in_acc = in_valid && !in_stall;
	assign start  = in_acc && (mode == sha256_pkg::MODE_MSG) && (word_index == 4'd15);

	always_comb begin
		load_words     = window_q;
		load_words[15] = data_word;
	end

	always_comb begin
		state_nx         = state_q;
		in_stall         = 1'b1;
		out_valid        = 1'b0;
		sched_ctrl.load  = 1'b0;
		sched_ctrl.shift = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				in_stall        = 1'b0;
				sched_ctrl.load = start;
				if (start) begin
					state_nx = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				sched_ctrl.shift = 1'b1;
				if (rnd_q == 6'(sha256_pkg::ROUNDS - 1)) begin
					state_nx = sha256_pkg::ST_ADD;
				end
			end
			sha256_pkg::ST_ADD: begin
				state_nx = sha256_pkg::ST_EMIT;
			end
			sha256_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall && idx_q == 3'd7) begin
					state_nx = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			idx_q <= '0;
		end else begin
			if (start) begin
				rnd_q <= '0;
			end else if (state_q == sha256_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == sha256_pkg::ST_ADD) begin
				idx_q <= '0;
			end else if (out_valid && !out_stall) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha256_pkg::INIT_HASH;
			v_q     <= '0;
		end else begin
			if (in_acc && mode == sha256_pkg::MODE_IV) begin
				chain_q <= sha256_pkg::INIT_HASH;
			end else if (in_acc && mode == sha256_pkg::MODE_CHAIN && !word_index[3]) begin
				chain_q[word_index[2:0]] <= data_word;
			end else if (state_q == sha256_pkg::ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (start) begin
				v_q <= chain_q;
			end else if (state_q == sha256_pkg::ST_ROUND) begin
				v_q <= v_round;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == sha256_pkg::MODE_MSG) begin
			window_q[word_index] <= data_word;
		end
	end

	sha256_sched u_sched (
		.clk        (clk),
		.ctrl       (sched_ctrl),
		.load_words (load_words),
		.wt         (wt)
	);

	sha256_round u_round (
		.v_in  (v_q),
		.k     (sha256_pkg::ROUND_K[rnd_q]),
		.w     (wt),
		.v_out (v_round)
	);

	assign digest_word  = chain_q[idx_q];
	assign digest_index = idx_q;
	assign digest_last  = (idx_q == 3'd7);

endmodule

FILE: rtl/sha256_chk.sv
// Port checker for the SHA-256 compression block, bound to the top level.
// Depends on sha256_compression_macros.svh and sha256_compression.
`include "sha256_compression_macros.svh"

module sha256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  digest_index,
	input logic        digest_last
);

	`SHA_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "digest item during reset")
	`SHA_ASSERT(a_stall_while_emit, out_valid |-> in_stall, "input taken during digest output")
	`SHA_ASSERT(a_last_marks_seven, out_valid |-> (digest_last == (digest_index == 3'd7)), "last flag off word seven")
	`SHA_ASSERT(a_idle_after_last, (out_valid && !out_stall && digest_last) |=> !out_valid, "item after last digest word")
	`SHA_ASSERT(a_hold_stalled, (out_valid && out_stall) |=> (out_valid && $stable(digest_word) && $stable(digest_index)), "stalled digest item changed")

endmodule

bind sha256_compression sha256_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.digest_word  (digest_word),
	.digest_index (digest_index),
	.digest_last  (digest_last)
);

FILE: test/tb_top.sv
// Testbench for the SHA-256 compression block: known vector, special items, random blocks.
// Depends on sha256_pkg and sha256_compression; digests are predicted by a local model.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 80;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [31:0] dword;
		logic [2:0]  didx;
		logic        dlast;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = sha256_pkg::MODE_IV;
	logic [3:0]  word_index = 4'd0;
	logic [31:0] data_word = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	logic [31:0] chain_q [8];
	logic [31:0] window_q [16];
	digest_t     expected_digests [$];
	digest_t     want;

	int mismatch_count = 0;
	int active_items = 0;
	int blocks_hashed = 0;
	int digests_checked = 0;
	int burst_left = 0;
	int stall_run = 0;
	int stall_pct = 50;
	int stall_cycle = 0;
	bit stall_now = 1'b0;

	sha256_compression uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.word_index(word_index),
		.data_word(data_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.digest_index(digest_index),
		.digest_last(digest_last)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		digest_t d;
		int slot;
		for (int i = 0; i < 16; i++) w[i] = window_q[i];
		for (int i = 0; i < 8; i++) v[i] = chain_q[i];
		for (int i = 0; i < sha256_pkg::ROUNDS; i++) begin
			slot = i % 16;
			if (i >= 16) begin
				w[slot] = ssig1(w[(i - 2) % 16]) + w[(i - 7) % 16]
					+ ssig0(w[(i - 15) % 16]) + w[slot];
			end
			t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[slot];
			t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) begin
			chain_q[i] = chain_q[i] + v[i];
			d.dword = chain_q[i];
			d.didx = i[2:0];
			d.dlast = (i == 7);
			expected_digests.push_back(d);
		end
		blocks_hashed++;
	endfunction

	function automatic void apply_item(input logic [1:0] m, input logic [3:0] idx,
			input logic [31:0] data);
		case (m)
			sha256_pkg::MODE_IV: begin
				for (int i = 0; i < 8; i++) chain_q[i] = SHA_IV[i];
			end
			sha256_pkg::MODE_CHAIN: begin
				if (idx < 4'd8) chain_q[idx[2:0]] = data;
			end
			sha256_pkg::MODE_MSG: begin
				window_q[idx] = data;
				if (idx == 4'd15) compress_block();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [3:0] idx,
			input logic [31:0] data);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		word_index <= idx;
		data_word <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_item(m, idx, data);
		if (m != MODE_UNUSED && !(m == sha256_pkg::MODE_CHAIN && idx > 4'd7)) active_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(0, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_digests.size() != 0) @(posedge clk);
	endtask

	task automatic test_abc_vector();
		send_item(sha256_pkg::MODE_IV, 4'd0, 32'd0);
		send_item(sha256_pkg::MODE_MSG, 4'd0, 32'h6162_6380);
		for (int i = 1; i < 15; i++) send_item(sha256_pkg::MODE_MSG, i[3:0], 32'h0000_0000);
		send_item(sha256_pkg::MODE_MSG, 4'd15, 32'h0000_0018);
	endtask

	task automatic test_special_items();
		send_item(MODE_UNUSED, 4'd15, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_CHAIN, 4'd15, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_CHAIN, 4'd8, 32'h1234_5678);
		send_item(sha256_pkg::MODE_CHAIN, 4'd0, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_CHAIN, 4'd7, 32'h0000_0000);
		send_item(sha256_pkg::MODE_MSG, 4'd3, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_MSG, 4'd3, 32'h8000_0001);
		send_item(sha256_pkg::MODE_MSG, 4'd15, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_IV, 4'd15, 32'hffff_ffff);
		send_item(sha256_pkg::MODE_MSG, 4'd15, 32'h0000_0000);
	endtask

	task automatic test_random_blocks(input int count);
		int target;
		int half;
		bit drained;
		target = active_items + count;
		half = active_items + count / 2;
		drained = 1'b0;
		while (active_items < target) begin
			if (!drained && active_items >= half) begin
				drain_results();
				drained = 1'b1;
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 3))
					0: send_item(sha256_pkg::MODE_IV, 4'($urandom_range(0, 15)), $urandom);
					1: begin
						for (int i = 0; i < 8; i++)
							send_item(sha256_pkg::MODE_CHAIN, i[3:0], rand_word());
					end
					default: ;
				endcase
				for (int i = 0; i < 16; i++) begin
					if ($urandom_range(0, 9) == 0)
						send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
							rand_word());
					send_item(sha256_pkg::MODE_MSG, i[3:0], rand_word());
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
						rand_word());
			end
		end
	endtask

	always @(posedge clk) begin
		stall_cycle++;
		if (stall_cycle % 400 == 0) stall_pct = $urandom_range(0, 3) * 25;
		if (stall_run > 0) begin
			stall_run--;
		end else begin
			stall_run = $urandom_range(0, 7);
			stall_now = ($urandom_range(0, 99) < stall_pct);
		end
		out_stall <= stall_now;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_digests.size() == 0) begin
				$display("%0t: unexpected digest item: expected none, actual word %h index %0d",
					$time, digest_word, digest_index);
				mismatch_count++;
			end else begin
				want = expected_digests.pop_front();
				digests_checked++;
				if (digest_word !== want.dword) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, want.dword, digest_word);
					mismatch_count++;
				end
				if (digest_index !== want.didx) begin
					$display("%0t: digest_index expected %0d actual %0d",
						$time, want.didx, digest_index);
					mismatch_count++;
				end
				if (digest_last !== want.dlast) begin
					$display("%0t: digest_last expected %0d actual %0d",
						$time, want.dlast, digest_last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		for (int i = 0; i < 8; i++) chain_q[i] = SHA_IV[i];
		for (int i = 0; i < 16; i++) window_q[i] = 32'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_abc_vector();
		test_special_items();
		test_random_blocks(250);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_digests.size() != 0) begin
			$display("%0t: %0d digest items never arrived", $time, expected_digests.size());
			mismatch_count++;
		end
		$display("Sent %0d active items covering %0d compressed blocks,", active_items,
			blocks_hashed);
		$display("with %0d digest words checked under random input gaps and output stalls.",
			digests_checked);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
